// ===== hdl/tlbpt_pkg.sv =====
// Shared types and constants for the TLB / page-table translator.
package tlbpt_pkg;

  localparam int TLB_ENTRIES = 16;
  localparam int FRAME_COUNT = 256;
  localparam int PAGE_BYTES  = 256;

  localparam int ADDR_W  = 16;
  localparam int PAGE_W  = 8;
  localparam int OFF_W   = 8;
  localparam int FRAME_W = 8;
  localparam int CNT_W   = 16;
  localparam int PAGE_COUNT = 1 << PAGE_W;
  localparam int TLB_IDX_W  = $clog2(TLB_ENTRIES);

  localparam logic [FRAME_W-1:0] FRAME_LAST = FRAME_W'(FRAME_COUNT - 1);
  localparam logic [CNT_W-1:0]   CNT_MAX    = {CNT_W{1'b1}};

  typedef enum logic {
    ST_IDLE,
    ST_LOOK
  } state_t;

  // TLB lookup answer
  typedef struct packed {
    logic               hit;
    logic [FRAME_W-1:0] frame;
  } tlb_look_t;

  // TLB fill request
  typedef struct packed {
    logic               en;
    logic [PAGE_W-1:0]  page;
    logic [FRAME_W-1:0] frame;
  } tlb_fill_t;

endpackage

// ===== hdl/tlbpt_tlb.sv =====
// Fully associative TLB with FIFO replacement.
module tlbpt_tlb (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [tlbpt_pkg::PAGE_W-1:0] page,
  input  tlbpt_pkg::tlb_fill_t      fill,
  output tlbpt_pkg::tlb_look_t      look
);

  logic [tlbpt_pkg::TLB_ENTRIES-1:0] valid;
  logic [tlbpt_pkg::PAGE_W-1:0]      tag   [tlbpt_pkg::TLB_ENTRIES];
  logic [tlbpt_pkg::FRAME_W-1:0]     frame [tlbpt_pkg::TLB_ENTRIES];
  logic [tlbpt_pkg::TLB_IDX_W-1:0]   oldest;

  // lowest matching entry wins
  always_comb begin
    look = '0;
    for (int i = tlbpt_pkg::TLB_ENTRIES - 1; i >= 0; i--) begin
      if (valid[i] && tag[i] == page) begin
        look.hit   = 1'b1;
        look.frame = frame[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid  <= '0;
      oldest <= '0;
    end else if (fill.en) begin
      valid[oldest] <= 1'b1;
      if (oldest == tlbpt_pkg::TLB_IDX_W'(tlbpt_pkg::TLB_ENTRIES - 1)) begin
        oldest <= '0;
      end else begin
        oldest <= oldest + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fill.en) begin
      tag[oldest]   <= fill.page;
      frame[oldest] <= fill.frame;
    end
  end

endmodule

// ===== hdl/tlb_page_table_translator_top.sv =====
// Top level of the TLB / page-table address translator.
//
// Input channel: logical_address with in_valid / in_stall. A transaction
// completes on a clock edge with in_valid high and in_stall low.
// Output channel: physical_address, tlb_hit, page_fault, hit_total and
// fault_total with out_valid / out_stall, one result per input transaction.
//
// On the accept edge the page-table read is issued (synchronous memory);
// once the output register is free, the finishing edge resolves the TLB
// lookup, page-table entry and frame allocation, writes back the table and
// TLB, and loads the output register. A new address is not accepted until
// the current one has finished; in_stall is high meanwhile.
// out_valid rises when the result is loaded into the output register.
//
// Reset (rst, synchronous) clears the TLB and page-table valid bits, the
// FIFO pointer, the free-frame pointer and both counters; no sweep needed.
// When the receiver stalls, the result holds in the output register; a
// finished lookup waits for that register, and in_stall stays high.
module tlb_page_table_translator_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [tlbpt_pkg::ADDR_W-1:0]  logical_address,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [tlbpt_pkg::ADDR_W-1:0]  physical_address,
  output logic                          tlb_hit,
  output logic                          page_fault,
  output logic [tlbpt_pkg::CNT_W-1:0]   hit_total,
  output logic [tlbpt_pkg::CNT_W-1:0]   fault_total
);

  tlbpt_pkg::state_t state, state_next;

  logic [tlbpt_pkg::PAGE_W-1:0]  page;
  logic [tlbpt_pkg::OFF_W-1:0]   offset;
  logic [tlbpt_pkg::FRAME_W-1:0] rd_frame;
  logic [tlbpt_pkg::FRAME_W-1:0] free_frame;
  logic [tlbpt_pkg::CNT_W-1:0]   hit_counter;
  logic [tlbpt_pkg::CNT_W-1:0]   fault_counter;

  // page table: valid bits in flops, frames in a synchronous RAM
  logic [tlbpt_pkg::PAGE_COUNT-1:0] table_valid;
  logic [tlbpt_pkg::FRAME_W-1:0]    table_frame [tlbpt_pkg::PAGE_COUNT];

  tlbpt_pkg::tlb_look_t look;
  tlbpt_pkg::tlb_fill_t fill;

  logic                          accept;
  logic                          out_free;
  logic                          finish;
  logic                          entry_ok;
  logic                          fault;
  logic [tlbpt_pkg::FRAME_W-1:0] frame;

  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  tlbpt_tlb u_tlb (
    .clk  (clk),
    .rst  (rst),
    .page (page),
    .fill (fill),
    .look (look)
  );

  // resolve: TLB first, then page table, else allocate a frame
  always_comb begin
    entry_ok = table_valid[page];
    fault    = !look.hit && !entry_ok;
    if (look.hit) begin
      frame = look.frame;
    end else if (entry_ok) begin
      frame = rd_frame;
    end else begin
      frame = free_frame;
    end
    fill.en    = finish && !look.hit;
    fill.page  = page;
    fill.frame = frame;
  end

  // control FSM
  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    finish     = 1'b0;
    case (state)
      tlbpt_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          state_next = tlbpt_pkg::ST_LOOK;
        end
      end
      tlbpt_pkg::ST_LOOK: begin
        if (out_free) begin
          finish     = 1'b1;
          state_next = tlbpt_pkg::ST_IDLE;
        end
      end
      default: state_next = tlbpt_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tlbpt_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // capture the address and read the table on accept
  always_ff @(posedge clk) begin
    if (accept) begin
      page     <= logical_address[tlbpt_pkg::ADDR_W-1:tlbpt_pkg::OFF_W];
      offset   <= logical_address[tlbpt_pkg::OFF_W-1:0];
      rd_frame <= table_frame[logical_address[tlbpt_pkg::ADDR_W-1:tlbpt_pkg::OFF_W]];
    end
  end

  always_ff @(posedge clk) begin
    if (finish && fault) begin
      table_frame[page] <= free_frame;
    end
  end

  // allocation state, valid bits, counters
  always_ff @(posedge clk) begin
    if (rst) begin
      table_valid   <= '0;
      free_frame    <= '0;
      hit_counter   <= '0;
      fault_counter <= '0;
    end else if (finish) begin
      if (look.hit) begin
        if (hit_counter != tlbpt_pkg::CNT_MAX) begin
          hit_counter <= hit_counter + 1'b1;
        end
      end
      if (fault) begin
        table_valid[page] <= 1'b1;
        if (free_frame == tlbpt_pkg::FRAME_LAST) begin
          free_frame <= '0;
        end else begin
          free_frame <= free_frame + 1'b1;
        end
        if (fault_counter != tlbpt_pkg::CNT_MAX) begin
          fault_counter <= fault_counter + 1'b1;
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      physical_address <= {frame, offset};
      tlb_hit          <= look.hit;
      page_fault       <= fault;
      if (look.hit && hit_counter != tlbpt_pkg::CNT_MAX) begin
        hit_total <= hit_counter + 1'b1;
      end else begin
        hit_total <= hit_counter;
      end
      if (fault && fault_counter != tlbpt_pkg::CNT_MAX) begin
        fault_total <= fault_counter + 1'b1;
      end else begin
        fault_total <= fault_counter;
      end
    end
  end

endmodule
